>>> sv/ac_pkg.sv
package ac_pkg;

   localparam int MAX_NODES    = 4096;
   localparam int ALPHABET     = 26;
   localparam int MAX_PATTERNS = 1024;

   localparam int NODE_W  = 12;
   localparam int SYM_W   = 5;
   localparam int ID_W    = 11;
   localparam int CNT_W   = 32;
   localparam int LEN_W   = 13;
   localparam int GOTO_AW = NODE_W + SYM_W;

   typedef enum logic [2:0] {
      REQ_CLEAR   = 3'd0,
      REQ_PATTERN = 3'd1,
      REQ_BUILD   = 3'd2,
      REQ_TEXT    = 3'd3,
      REQ_PROP    = 3'd4,
      REQ_QUERY   = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_BADID = 2'd2,
      ST_PHASE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_LOAD    = 2'd0,
      PH_MATCH   = 2'd1,
      PH_COUNTED = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DISP,
      S_P_CHK, S_P_ALLOC, S_P_END,
      S_B_ROOT, S_B_ROOTCHK, S_B_HEAD, S_B_U, S_B_F, S_B_A1, S_B_A2, S_B_A3,
      S_T_C, S_T_W,
      S_G_K, S_G_U, S_G_F, S_G_W,
      S_Q_C, S_Q_D,
      S_DONE
   } state_type;

endpackage

>>> sv/ac_ram.sv
module ac_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/ac_sat_add.sv
module ac_sat_add (
   input  logic [ac_pkg::CNT_W-1:0] a,
   input  logic [ac_pkg::CNT_W-1:0] b,
   output logic [ac_pkg::CNT_W-1:0] sum
);
   import ac_pkg::*;

   logic [CNT_W:0] wide;

   always_comb begin
      wide = {1'b0, a} + {1'b0, b};
      sum  = wide[CNT_W] ? {CNT_W{1'b1}} : wide[CNT_W-1:0];
   end

endmodule

>>> sv/multi_pattern_occurrence_counter_unit.sv
// channel   dir  tdata (low bit first)                 tuser        tlast
// req_      in   symbol[4:0], pattern_id[15:5]         req_type     pattern_end
// rsp_      out  occurrences[31:0], echo_id[42:32]     status       -
//
// one request at a time under a sequencer; a text symbol takes a goto read, a count read
// and a count write; a query reads the pattern table, then the count; a pattern symbol
// checks its edge, a new node adds a row clearing sweep; one port each way per memory
// build: a read and a check per root column, then per queued node a dequeue, a failure
// read, and two goto reads and a write per column; propagate: reverse breadth-first order
// reset and clear run a clearing pass over the pattern table and root row
// a finished response waits in its register while the next request is taken; the
// sequencer only stalls in its last state while that register is still full
module multi_pattern_occurrence_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // symbol, pattern_id
   input  logic [2:0]  req_tuser,   // req_type
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // occurrences, echo_id, zero fill
   output logic [1:0]  rsp_tuser    // status
);
   import ac_pkg::*;

   state_type state_ff, state_in;

   // latched request
   logic [2:0]        req_ff, req_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              pend_ff, pend_in;
   logic [ID_W-1:0]   id_ff, id_in;

   // automaton control state
   logic [NODE_W-1:0] ins_ff, ins_in;
   logic [NODE_W-1:0] text_ff, text_in;
   logic [LEN_W-1:0]  used_ff, used_in;
   logic [LEN_W-1:0]  bfs_len_ff, bfs_len_in;
   phase_type         phase_ff, phase_in;

   // sequencer working registers
   logic [LEN_W-1:0]  head_ff, head_in;
   logic [LEN_W-1:0]  tail_ff, tail_in;
   logic [SYM_W-1:0]  col_ff, col_in;
   logic [NODE_W-1:0] u_ff, u_in;
   logic [NODE_W-1:0] fu_ff, fu_in;
   logic [NODE_W-1:0] v_ff, v_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ID_W-1:0]   clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [1:0]        status_ff, status_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic [ID_W-1:0]   rsp_echo_ff, rsp_echo_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // memory ports
   logic               goto_we, fail_we, count_we, bfs_we, pat_we;
   logic [GOTO_AW-1:0] goto_waddr, goto_raddr;
   logic [NODE_W-1:0]  goto_wdata, goto_rd;
   logic [NODE_W-1:0]  fail_waddr, fail_raddr, fail_wdata, fail_rd;
   logic [NODE_W-1:0]  count_waddr, count_raddr;
   logic [CNT_W-1:0]   count_wdata, count_rd;
   logic [NODE_W-1:0]  bfs_waddr, bfs_raddr, bfs_wdata, bfs_rd;
   logic [ID_W-1:0]    pat_waddr, pat_raddr;
   logic [NODE_W:0]    pat_wdata, pat_rd;

   // shared saturating adder
   logic [CNT_W-1:0]   add_a, add_b, add_sum;

   logic accept, sym_ok, id_ok, tail_room, rsp_free;

   ac_ram #(.ADDR_W(GOTO_AW), .DATA_W(NODE_W)) u_goto (
      .clock(clock), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
      .raddr(goto_raddr), .rdata(goto_rd));
   ac_ram #(.ADDR_W(NODE_W), .DATA_W(NODE_W)) u_fail (
      .clock(clock), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
      .raddr(fail_raddr), .rdata(fail_rd));
   ac_ram #(.ADDR_W(NODE_W), .DATA_W(CNT_W)) u_count (
      .clock(clock), .we(count_we), .waddr(count_waddr), .wdata(count_wdata),
      .raddr(count_raddr), .rdata(count_rd));
   ac_ram #(.ADDR_W(NODE_W), .DATA_W(NODE_W)) u_bfs (
      .clock(clock), .we(bfs_we), .waddr(bfs_waddr), .wdata(bfs_wdata),
      .raddr(bfs_raddr), .rdata(bfs_rd));
   // pattern table: valid bit over end node
   ac_ram #(.ADDR_W(ID_W), .DATA_W(NODE_W + 1)) u_pat (
      .clock(clock), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
      .raddr(pat_raddr), .rdata(pat_rd));

   ac_sat_add u_add (.a(add_a), .b(add_b), .sum(add_sum));

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sym_ok     = (sym_ff < SYM_W'(ALPHABET));
   assign id_ok      = (id_ff != '0) && (id_ff <= ID_W'(MAX_PATTERNS));
   assign tail_room  = (tail_ff < LEN_W'(MAX_NODES));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_echo_ff, rsp_occ_ff};
   assign rsp_tuser  = rsp_status_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            if (&clr_ff) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == REQ_CLEAR) ? S_CLR : S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            case (req_ff)
               REQ_PATTERN: if (phase_ff == PH_LOAD && sym_ok) state_in = S_P_CHK;
               REQ_BUILD:   if (phase_ff == PH_LOAD) state_in = S_B_ROOT;
               REQ_TEXT:    if (phase_ff == PH_MATCH && sym_ok) state_in = S_T_C;
               REQ_PROP:    if (phase_ff == PH_MATCH) state_in = S_G_K;
               REQ_QUERY:   if (phase_ff == PH_COUNTED && id_ok) state_in = S_Q_C;
               default:     state_in = S_DONE;
            endcase
         end
         S_P_CHK: begin
            if (goto_rd != '0) begin
               state_in = S_P_END;
            end else if (used_ff >= LEN_W'(MAX_NODES)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_P_ALLOC;
            end
         end
         S_P_ALLOC:   if (&col_ff) state_in = S_P_END;
         S_P_END:     state_in = S_DONE;
         S_B_ROOT:    state_in = S_B_ROOTCHK;
         S_B_ROOTCHK: state_in = (col_ff == SYM_W'(ALPHABET - 1)) ? S_B_HEAD : S_B_ROOT;
         S_B_HEAD:    state_in = (head_ff == tail_ff) ? S_DONE : S_B_U;
         S_B_U:       state_in = S_B_F;
         S_B_F:       state_in = S_B_A1;
         S_B_A1:      state_in = S_B_A2;
         S_B_A2:      state_in = S_B_A3;
         S_B_A3:      state_in = (col_ff == SYM_W'(ALPHABET - 1)) ? S_B_HEAD : S_B_A1;
         S_T_C:       state_in = S_T_W;
         S_T_W:       state_in = S_DONE;
         S_G_K:       state_in = (head_ff == '0) ? S_DONE : S_G_U;
         S_G_U:       state_in = S_G_F;
         S_G_F:       state_in = S_G_W;
         S_G_W:       state_in = S_G_K;
         S_Q_C:       state_in = pat_rd[NODE_W] ? S_Q_D : S_DONE;
         S_Q_D:       state_in = S_DONE;
         S_DONE:      if (rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in      = req_ff;
      sym_in      = sym_ff;
      pend_in     = pend_ff;
      id_in       = id_ff;
      ins_in      = ins_ff;
      text_in     = text_ff;
      used_in     = used_ff;
      bfs_len_in  = bfs_len_ff;
      phase_in    = phase_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      col_in      = col_ff;
      u_in        = u_ff;
      fu_in       = fu_ff;
      v_in        = v_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      clr_rsp_in  = clr_rsp_ff;
      status_in   = status_ff;
      occ_in      = occ_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_occ_in    = rsp_occ_ff;
      rsp_echo_in   = rsp_echo_ff;
      rsp_status_in = rsp_status_ff;

      goto_we = 1'b0;  goto_waddr = '0;  goto_wdata = '0;  goto_raddr = '0;
      fail_we = 1'b0;  fail_waddr = '0;  fail_wdata = '0;  fail_raddr = '0;
      count_we = 1'b0; count_waddr = '0; count_wdata = '0; count_raddr = '0;
      bfs_we = 1'b0;   bfs_waddr = '0;   bfs_wdata = '0;   bfs_raddr = '0;
      pat_we = 1'b0;   pat_waddr = '0;   pat_wdata = '0;   pat_raddr = '0;
      add_a = count_rd;
      add_b = cnt_ff;

      case (state_ff)
         S_CLR: begin
            pat_we    = 1'b1;
            pat_waddr = clr_ff;
            if (clr_ff < ID_W'(2 ** SYM_W)) begin
               goto_we    = 1'b1;
               goto_waddr = {NODE_W'(0), clr_ff[SYM_W-1:0]};
            end
            if (clr_ff == '0) begin
               fail_we  = 1'b1;
               count_we = 1'b1;
            end
            clr_in = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               req_in    = req_tuser;
               sym_in    = req_tdata[4:0];
               id_in     = req_tdata[15:5];
               pend_in   = req_tlast;
               status_in = ST_OK;
               occ_in    = '0;
               if (req_tuser == REQ_CLEAR) begin
                  used_in    = LEN_W'(1);
                  ins_in     = '0;
                  text_in    = '0;
                  bfs_len_in = '0;
                  phase_in   = PH_LOAD;
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
               end
            end
         end
         S_DISP: begin
            case (req_ff)
               REQ_PATTERN: begin
                  if (phase_ff != PH_LOAD) status_in = ST_PHASE;
                  goto_raddr = {ins_ff, sym_ff};
               end
               REQ_BUILD: begin
                  if (phase_ff != PH_LOAD) status_in = ST_PHASE;
                  tail_in = '0;
                  col_in  = '0;
               end
               REQ_TEXT: begin
                  if (phase_ff != PH_MATCH) status_in = ST_PHASE;
                  goto_raddr = {text_ff, sym_ff};
               end
               REQ_PROP: begin
                  if (phase_ff != PH_MATCH) status_in = ST_PHASE;
                  head_in = bfs_len_ff;
               end
               REQ_QUERY: begin
                  if (phase_ff != PH_COUNTED) begin
                     status_in = ST_PHASE;
                  end else if (!id_ok) begin
                     status_in = ST_BADID;
                  end
                  pat_raddr = id_ff;
               end
               default: status_in = ST_PHASE;
            endcase
         end
         S_P_CHK: begin
            col_in = '0;
            if (goto_rd != '0) begin
               v_in = goto_rd;
            end else if (used_ff >= LEN_W'(MAX_NODES)) begin
               status_in = ST_FULL;
               if (pend_ff) ins_in = '0;
            end else begin
               v_in       = used_ff[NODE_W-1:0];
               used_in    = used_ff + 1'b1;
               goto_we    = 1'b1;
               goto_waddr = {ins_ff, sym_ff};
               goto_wdata = used_ff[NODE_W-1:0];
            end
         end
         S_P_ALLOC: begin
            // clear the new node's row
            goto_we    = 1'b1;
            goto_waddr = {v_ff, col_ff};
            if (col_ff == '0) begin
               fail_we     = 1'b1;
               fail_waddr  = v_ff;
               count_we    = 1'b1;
               count_waddr = v_ff;
            end
            col_in = col_ff + 1'b1;
         end
         S_P_END: begin
            ins_in = v_ff;
            if (pend_ff) begin
               ins_in = '0;
               if (id_ok) begin
                  pat_we    = 1'b1;
                  pat_waddr = id_ff;
                  pat_wdata = {1'b1, v_ff};
               end else begin
                  status_in = ST_BADID;
               end
            end
         end
         S_B_ROOT: begin
            goto_raddr = {NODE_W'(0), col_ff};
         end
         S_B_ROOTCHK: begin
            if (goto_rd != '0 && tail_room) begin
               fail_we    = 1'b1;
               fail_waddr = goto_rd;
               bfs_we     = 1'b1;
               bfs_waddr  = tail_ff[NODE_W-1:0];
               bfs_wdata  = goto_rd;
               tail_in    = tail_ff + 1'b1;
            end
            if (col_ff == SYM_W'(ALPHABET - 1)) begin
               head_in = '0;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_B_HEAD: begin
            if (head_ff == tail_ff) begin
               bfs_len_in = tail_ff;
               ins_in     = '0;
               text_in    = '0;
               phase_in   = PH_MATCH;
            end else begin
               bfs_raddr = head_ff[NODE_W-1:0];
               head_in   = head_ff + 1'b1;
            end
         end
         S_B_U: begin
            u_in       = bfs_rd;
            fail_raddr = bfs_rd;
            col_in     = '0;
         end
         S_B_F: begin
            fu_in = fail_rd;
         end
         S_B_A1: begin
            goto_raddr = {u_ff, col_ff};
         end
         S_B_A2: begin
            v_in       = goto_rd;
            goto_raddr = {fu_ff, col_ff};
         end
         S_B_A3: begin
            if (v_ff == '0) begin
               // missing edge takes the failure node's edge
               goto_we    = 1'b1;
               goto_waddr = {u_ff, col_ff};
               goto_wdata = goto_rd;
            end else begin
               fail_we    = 1'b1;
               fail_waddr = v_ff;
               fail_wdata = goto_rd;
               if (tail_room) begin
                  bfs_we    = 1'b1;
                  bfs_waddr = tail_ff[NODE_W-1:0];
                  bfs_wdata = v_ff;
                  tail_in   = tail_ff + 1'b1;
               end
            end
            col_in = col_ff + 1'b1;
         end
         S_T_C: begin
            text_in     = goto_rd;
            v_in        = goto_rd;
            count_raddr = goto_rd;
         end
         S_T_W: begin
            add_b       = CNT_W'(1);
            count_we    = 1'b1;
            count_waddr = v_ff;
            count_wdata = add_sum;
         end
         S_G_K: begin
            if (head_ff == '0) begin
               phase_in = PH_COUNTED;
            end else begin
               bfs_raddr = NODE_W'(head_ff - 1'b1);
               head_in   = head_ff - 1'b1;
            end
         end
         S_G_U: begin
            fail_raddr  = bfs_rd;
            count_raddr = bfs_rd;
         end
         S_G_F: begin
            fu_in       = fail_rd;
            cnt_in      = count_rd;
            count_raddr = fail_rd;
         end
         S_G_W: begin
            count_we    = 1'b1;
            count_waddr = fu_ff;
            count_wdata = add_sum;
         end
         S_Q_C: begin
            if (pat_rd[NODE_W]) begin
               count_raddr = pat_rd[NODE_W-1:0];
            end else begin
               status_in = ST_BADID;
            end
         end
         S_Q_D: begin
            occ_in = count_rd;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_occ_in    = occ_ff;
               rsp_echo_in   = (req_ff == REQ_QUERY) ? id_ff : '0;
               rsp_status_in = status_ff;
               clr_rsp_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ins_ff       <= '0;
         text_ff      <= '0;
         used_ff      <= LEN_W'(1);
         bfs_len_ff   <= '0;
         phase_ff     <= PH_LOAD;
         req_ff       <= REQ_CLEAR;
         status_ff    <= ST_OK;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         ins_ff       <= ins_in;
         text_ff      <= text_in;
         used_ff      <= used_in;
         bfs_len_ff   <= bfs_len_in;
         phase_ff     <= phase_in;
         req_ff       <= req_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      pend_ff       <= pend_in;
      id_ff         <= id_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      col_ff        <= col_in;
      u_ff          <= u_in;
      fu_ff         <= fu_in;
      v_ff          <= v_in;
      cnt_ff        <= cnt_in;
      occ_ff        <= occ_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_echo_ff   <= rsp_echo_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
